>>> sv/dfs_pkg.sv
package dfs_pkg;

   // Field widths
   localparam int COORD_W = 16;
   localparam int SUM_W   = 40;
   localparam int COUNT_W = 16;

   // Parameter defaults
   localparam int POINTS_PER_FRAME_DEF = 11;
   localparam int COORD_FRAC_BITS_DEF  = 8;

   // Saturation limits
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Q24.16 fraction bits of the sum
   localparam int SUM_FRAC_BITS = 16;

   // One stored point: x in the high half, y in the low half
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   // Scaled squared differences of one point against one bank
   typedef struct packed {
      logic [SUM_W-1:0] x;
      logic [SUM_W-1:0] y;
   } sq_pair_type;

   // Point bank write from the decide stage
   typedef struct packed {
      logic      en;
      logic      bank;
      point_type point;
   } write_req_type;

   // Squared difference of two coordinates, scaled to Q24.16 and saturated
   function automatic logic [SUM_W-1:0] scaled_square(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input int                        frac_bits
   );
      logic signed [COORD_W:0]     diff;
      logic        [COORD_W:0]     mag;
      logic        [2*COORD_W-1:0] sq;
      logic        [55:0]          wide;
      int                          frac2;
      diff  = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      mag   = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
      sq    = mag[COORD_W-1:0] * mag[COORD_W-1:0];
      wide  = {24'd0, sq};
      frac2 = 2 * frac_bits;
      if (frac2 < SUM_FRAC_BITS) begin
         wide = wide << (SUM_FRAC_BITS - frac2);
      end else if (frac2 > SUM_FRAC_BITS) begin
         wide = wide >> (frac2 - SUM_FRAC_BITS);
      end
      return (|wide[55:SUM_W]) ? SUM_MAX : wide[SUM_W-1:0];
   endfunction

endpackage

>>> sv/dfs_if.sv
// Point request channel
interface dfs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dfs_pkg::COORD_W-1:0]  x_coord;
   logic signed [dfs_pkg::COORD_W-1:0]  y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// Frame result channel
interface dfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          keep_frame;
   logic [dfs_pkg::SUM_W-1:0]     frame_distance;
   logic [dfs_pkg::COUNT_W-1:0]   kept_count;

   modport source (output valid, output keep_frame, output frame_distance,
                   output kept_count, input ready);
   modport sink   (input valid, input keep_frame, input frame_distance,
                   input kept_count, output ready);
endinterface

// Threshold write channel
interface dfs_csr_if;
   logic                      valid;
   logic                      ready;
   logic [dfs_pkg::SUM_W-1:0] change_threshold;

   modport source (output valid, output change_threshold, input ready);
   modport sink   (input valid, input change_threshold, output ready);
endinterface

>>> sv/dfs_ram.sv
// Generic RAM: one write port, two registered read ports (read-first)
module dfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

>>> sv/dfs_square_stage.sv
// Squared differences of the incoming point against both banks
module dfs_square_stage #(
   parameter int COORD_FRAC_BITS = dfs_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  advance,
   input  dfs_pkg::point_type    point,
   input  dfs_pkg::point_type    ref0,
   input  dfs_pkg::point_type    ref1,
   output dfs_pkg::sq_pair_type  sq0,
   output dfs_pkg::sq_pair_type  sq1
);

   dfs_pkg::sq_pair_type sq0_ff, sq0_in;
   dfs_pkg::sq_pair_type sq1_ff, sq1_in;

   // One multiplier per coordinate and bank
   always_comb begin
      sq0_in.x = dfs_pkg::scaled_square(point.x, ref0.x, COORD_FRAC_BITS);
      sq0_in.y = dfs_pkg::scaled_square(point.y, ref0.y, COORD_FRAC_BITS);
      sq1_in.x = dfs_pkg::scaled_square(point.x, ref1.x, COORD_FRAC_BITS);
      sq1_in.y = dfs_pkg::scaled_square(point.y, ref1.y, COORD_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq0_ff <= sq0_in;
         sq1_ff <= sq1_in;
      end
   end

   assign sq0 = sq0_ff;
   assign sq1 = sq1_ff;

endmodule

>>> sv/dfs_decide_stage.sv
// Accumulate, end-of-frame decision, bank write-back and result register
module dfs_decide_stage #(
   parameter int POINTS_PER_FRAME = dfs_pkg::POINTS_PER_FRAME_DEF,
   localparam int IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic                         in_last,
   input  logic [IDX_W-1:0]             in_idx,
   input  dfs_pkg::point_type           in_point,
   input  dfs_pkg::sq_pair_type         sq0,
   input  dfs_pkg::sq_pair_type         sq1,
   input  logic [dfs_pkg::SUM_W-1:0]    threshold,
   output logic                         result_block,
   output dfs_pkg::write_req_type       wr_req,
   output logic [IDX_W-1:0]             wr_idx,
   dfs_rsp_if.source                    rsp_stream
);

   localparam int SUM_W   = dfs_pkg::SUM_W;
   localparam int COUNT_W = dfs_pkg::COUNT_W;

   logic                     r2_valid_ff;
   logic                     r2_last_ff;
   logic [IDX_W-1:0]         r2_idx_ff;
   dfs_pkg::point_type       r2_point_ff;

   logic [SUM_W-1:0]         sum_ff;
   logic                     ref_bank_ff;
   logic                     have_ref_ff;
   logic [COUNT_W-1:0]       kept_ff, kept_in;

   logic                     rsp_valid_ff;
   logic                     rsp_keep_ff;
   logic [SUM_W-1:0]         rsp_dist_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic [SUM_W-1:0]         sq_x, sq_y;
   logic [SUM_W+1:0]         total;
   logic [SUM_W-1:0]         acc_sum;
   logic                     keep;
   logic                     fire;

   // Result slot still occupied when a frame ends
   assign result_block = r2_valid_ff && r2_last_ff && rsp_valid_ff && !rsp_stream.ready;
   assign fire         = r2_valid_ff && advance;

   // Terms against the settled reference bank
   always_comb begin
      sq_x    = ref_bank_ff ? sq1.x : sq0.x;
      sq_y    = ref_bank_ff ? sq1.y : sq0.y;
      total   = {2'b00, sum_ff} + {2'b00, sq_x} + {2'b00, sq_y};
      acc_sum = '0;
      if (have_ref_ff) begin
         acc_sum = (|total[SUM_W+1:SUM_W]) ? dfs_pkg::SUM_MAX : total[SUM_W-1:0];
      end
      keep    = !have_ref_ff || (acc_sum > threshold);
      kept_in = kept_ff;
      if (have_ref_ff && keep && (kept_ff != dfs_pkg::COUNT_MAX)) begin
         kept_in = kept_ff + COUNT_W'(1);
      end
   end

   // Point goes into the bank that is not the reference
   always_comb begin
      wr_req.en    = fire;
      wr_req.bank  = ~ref_bank_ff;
      wr_req.point = r2_point_ff;
      wr_idx       = r2_idx_ff;
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         r2_valid_ff <= 1'b0;
      end else if (advance) begin
         r2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r2_last_ff  <= in_last;
         r2_idx_ff   <= in_idx;
         r2_point_ff <= in_point;
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         ref_bank_ff <= 1'b0;
         have_ref_ff <= 1'b0;
         kept_ff     <= '0;
      end else if (fire) begin
         if (r2_last_ff) begin
            sum_ff      <= '0;
            have_ref_ff <= 1'b1;
            kept_ff     <= kept_in;
            if (keep) begin
               ref_bank_ff <= ~ref_bank_ff;
            end
         end else begin
            sum_ff <= acc_sum;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && r2_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && r2_last_ff) begin
         rsp_keep_ff  <= keep;
         rsp_dist_ff  <= acc_sum;
         rsp_count_ff <= kept_in;
      end
   end

   assign rsp_stream.valid          = rsp_valid_ff;
   assign rsp_stream.keep_frame     = rsp_keep_ff;
   assign rsp_stream.frame_distance = rsp_dist_ff;
   assign rsp_stream.kept_count     = rsp_count_ff;

endmodule

>>> sv/deadband_frame_selector.sv
// Channel      Dir   Payload                                   Request accepted on
// req_stream   in    x_coord, y_coord (Q8.8 signed)            valid && ready
// rsp_stream   out   keep_frame, frame_distance, kept_count    valid && ready
// csr_write    in    change_threshold (Q24.16, 40 bits)        valid && ready (ready tied high)
//
// One point per cycle while not stalled: input register with bank read, square stage,
// accumulate stage, then the result register that holds a frame result.
// Reset is synchronous; after it the first frame is taken as reference, no clearing pass.
// The pipeline stalls only when a frame ends while the result register still holds an
// untaken result; otherwise points keep flowing while a result waits.
module deadband_frame_selector #(
   parameter int POINTS_PER_FRAME = dfs_pkg::POINTS_PER_FRAME_DEF,
   parameter int COORD_FRAC_BITS  = dfs_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dfs_req_if.sink    req_stream,
   dfs_rsp_if.source  rsp_stream,
   dfs_csr_if.sink    csr_write
);

   localparam int IDX_W  = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
   localparam int DEPTH  = 2 * POINTS_PER_FRAME;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PT_W   = $bits(dfs_pkg::point_type);

   logic                       advance;
   logic                       accept;
   logic                       result_block;

   logic [dfs_pkg::SUM_W-1:0]  threshold_ff;

   logic [IDX_W-1:0]           idx_ff;
   logic                       idx_last;

   logic                       r1_valid_ff;
   logic                       r1_last_ff;
   logic [IDX_W-1:0]           r1_idx_ff;
   dfs_pkg::point_type         r1_point_ff;

   dfs_pkg::point_type         req_point;
   logic [PT_W-1:0]            ram_data0, ram_data1;
   dfs_pkg::point_type         ref0, ref1;

   dfs_pkg::write_req_type     wr_req;
   logic [IDX_W-1:0]           wr_idx;
   logic [ADDR_W-1:0]          wr_addr;

   logic                       lastwr_valid_ff;
   dfs_pkg::write_req_type     lastwr_ff;
   logic [IDX_W-1:0]           lastwr_idx_ff;

   dfs_pkg::sq_pair_type       sq0, sq1;

   // Handshake
   assign advance          = !result_block;
   assign req_stream.ready = advance;
   assign accept           = req_stream.valid && advance;
   assign csr_write.ready  = 1'b1;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write.valid) begin
         threshold_ff <= csr_write.change_threshold;
      end
   end

   // Point position within the frame
   assign idx_last = (idx_ff == IDX_W'(POINTS_PER_FRAME - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (accept) begin
         idx_ff <= idx_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   // Input register
   always_comb begin
      req_point.x = req_stream.x_coord;
      req_point.y = req_stream.y_coord;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
      end else if (advance) begin
         r1_valid_ff <= req_stream.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r1_last_ff  <= idx_last;
         r1_idx_ff   <= idx_ff;
         r1_point_ff <= req_point;
      end
   end

   // Point banks: bank 0 at 0..P-1, bank 1 at P..2P-1
   assign wr_addr = wr_req.bank ? ADDR_W'(POINTS_PER_FRAME) + ADDR_W'(wr_idx)
                                : ADDR_W'(wr_idx);

   dfs_ram #(
      .WIDTH (PT_W),
      .DEPTH (DEPTH)
   ) u_banks (
      .clock     (clock),
      .wr_en     (wr_req.en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_req.point),
      .rd_en     (accept),
      .rd_addr_a (ADDR_W'(idx_ff)),
      .rd_addr_b (ADDR_W'(POINTS_PER_FRAME) + ADDR_W'(idx_ff)),
      .rd_data_a (ram_data0),
      .rd_data_b (ram_data1)
   );

   // Last completed write, for a read that raced it
   always_ff @(posedge clock) begin
      if (reset) begin
         lastwr_valid_ff <= 1'b0;
      end else if (wr_req.en) begin
         lastwr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         lastwr_ff     <= wr_req;
         lastwr_idx_ff <= wr_idx;
      end
   end

   // Bypass of writes not yet seen by the bank read (short frames)
   always_comb begin
      ref0 = dfs_pkg::point_type'(ram_data0);
      ref1 = dfs_pkg::point_type'(ram_data1);
      if (lastwr_valid_ff && (lastwr_idx_ff == r1_idx_ff)) begin
         if (lastwr_ff.bank) begin
            ref1 = lastwr_ff.point;
         end else begin
            ref0 = lastwr_ff.point;
         end
      end
      if (wr_req.en && (wr_idx == r1_idx_ff)) begin
         if (wr_req.bank) begin
            ref1 = wr_req.point;
         end else begin
            ref0 = wr_req.point;
         end
      end
   end

   dfs_square_stage #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_square (
      .clock   (clock),
      .advance (advance),
      .point   (r1_point_ff),
      .ref0    (ref0),
      .ref1    (ref1),
      .sq0     (sq0),
      .sq1     (sq1)
   );

   dfs_decide_stage #(
      .POINTS_PER_FRAME (POINTS_PER_FRAME)
   ) u_decide (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (r1_valid_ff),
      .in_last      (r1_last_ff),
      .in_idx       (r1_idx_ff),
      .in_point     (r1_point_ff),
      .sq0          (sq0),
      .sq1          (sq1),
      .threshold    (threshold_ff),
      .result_block (result_block),
      .wr_req       (wr_req),
      .wr_idx       (wr_idx),
      .rsp_stream   (rsp_stream)
   );

endmodule
